// File: sv/ps2_controller_registers_core_assert.svh
// assertion macros shared by the checker files
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef PS2_CONTROLLER_REGISTERS_CORE_ASSERT_SVH
`define PS2_CONTROLLER_REGISTERS_CORE_ASSERT_SVH

// same-cycle implication, ignored while reset is asserted
`define PS2CR_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ps2cr assertion failed");

// next-cycle implication, ignored while reset is asserted
`define PS2CR_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ps2cr assertion failed");

// next-cycle implication that also holds across reset
`define PS2CR_ASSERT_NXT_ALWAYS(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ps2cr assertion failed");

`endif

// File: sv/ps2cr_pkg.sv
// types and constants of the ps/2 controller register block
// no dependencies
`timescale 1ns / 1ps

package ps2cr_pkg;

    typedef enum logic [1:0] {
        REQ_READ   = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_DEVICE = 2'd2
    } req_kind_t;

    localparam logic [7:0] CMD_READ_CFG   = 8'h20;
    localparam logic [7:0] CMD_WRITE_CFG  = 8'h60;
    localparam logic [7:0] CMD_DISABLE_B  = 8'hA7;
    localparam logic [7:0] CMD_ENABLE_B   = 8'hA8;
    localparam logic [7:0] CMD_TEST_B     = 8'hA9;
    localparam logic [7:0] CMD_SELF_TEST  = 8'hAA;
    localparam logic [7:0] CMD_TEST_A     = 8'hAB;
    localparam logic [7:0] CMD_DISABLE_A  = 8'hAD;
    localparam logic [7:0] CMD_ENABLE_A   = 8'hAE;
    localparam logic [7:0] CMD_WRITE_B    = 8'hD4;

    localparam logic [7:0] RESP_SELF_TEST = 8'h55;
    localparam logic [7:0] RESP_PORT_TEST = 8'h00;

    localparam logic [7:0] CFG_RESET      = 8'h30;
    localparam int         CFG_IRQ_A_BIT  = 0;
    localparam int         CFG_IRQ_B_BIT  = 1;
    localparam int         CFG_DIS_A_BIT  = 4;
    localparam int         CFG_DIS_B_BIT  = 5;

    localparam logic [1:0] PEND_NONE      = 2'd0;
    localparam logic [1:0] PEND_CFG       = 2'd1;
    localparam logic [1:0] PEND_PORT_B    = 2'd2;

    localparam logic [1:0] ST_OK            = 2'd0;
    localparam logic [1:0] ST_UNKNOWN       = 2'd1;
    localparam logic [1:0] ST_DROP_FULL     = 2'd2;
    localparam logic [1:0] ST_DROP_DISABLED = 2'd3;

    typedef struct packed {
        logic [1:0] req_type;
        logic       is_command_port;
        logic [7:0] host_data;
        logic       device_port;
        logic [7:0] device_data;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       send_valid;
        logic       send_port;
        logic [7:0] send_byte;
        logic       irq_a;
        logic       irq_b;
        logic [1:0] status;
    } result_t;

endpackage

// File: sv/ps2cr_exec.sv
// controller state and the decode of one item into its result
// depends on ps2cr_pkg
`timescale 1ns / 1ps

module ps2cr_exec
    import ps2cr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    fire,
    input  item_t   item,
    input  logic    second_port_present,
    output result_t res
);

    logic [7:0] config_reg,   config_next;
    logic [7:0] buffer_reg,   buffer_next;
    logic       full_reg,     full_next;
    logic       from_b_reg,   from_b_next;
    logic [1:0] pending_reg,  pending_next;
    logic       port_disabled;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            config_reg  <= CFG_RESET;
            buffer_reg  <= '0;
            full_reg    <= 1'b0;
            from_b_reg  <= 1'b0;
            pending_reg <= PEND_NONE;
        end else if (fire) begin
            config_reg  <= config_next;
            buffer_reg  <= buffer_next;
            full_reg    <= full_next;
            from_b_reg  <= from_b_next;
            pending_reg <= pending_next;
        end
    end

    assign port_disabled = item.device_port
                         ? (!second_port_present || config_reg[CFG_DIS_B_BIT])
                         : config_reg[CFG_DIS_A_BIT];

    always_comb begin
        config_next    = config_reg;
        buffer_next    = buffer_reg;
        full_next      = full_reg;
        from_b_next    = from_b_reg;
        pending_next   = pending_reg;
        res            = '0;
        res.status     = ST_OK;

        unique case (item.req_type)
            REQ_READ: begin
                if (item.is_command_port) begin
                    res.read_data = {2'b00, full_reg & from_b_reg, 4'b0000, full_reg};
                end else begin
                    res.read_data = buffer_reg;
                    full_next     = 1'b0;
                    from_b_next   = 1'b0;
                end
            end
            REQ_WRITE: begin
                if (item.is_command_port) begin
                    // any command cancels an armed data write
                    pending_next = PEND_NONE;
                    unique case (item.host_data)
                        CMD_READ_CFG: begin
                            buffer_next = config_reg;
                            full_next   = 1'b1;
                            from_b_next = 1'b0;
                        end
                        CMD_WRITE_CFG: pending_next = PEND_CFG;
                        CMD_WRITE_B: begin
                            if (second_port_present) pending_next = PEND_PORT_B;
                        end
                        CMD_DISABLE_B: begin
                            if (second_port_present) config_next[CFG_DIS_B_BIT] = 1'b1;
                        end
                        CMD_ENABLE_B: begin
                            if (second_port_present) config_next[CFG_DIS_B_BIT] = 1'b0;
                        end
                        CMD_TEST_B: begin
                            if (second_port_present) begin
                                buffer_next = RESP_PORT_TEST;
                                full_next   = 1'b1;
                                from_b_next = 1'b0;
                            end
                        end
                        CMD_SELF_TEST: begin
                            buffer_next = RESP_SELF_TEST;
                            full_next   = 1'b1;
                            from_b_next = 1'b0;
                        end
                        CMD_TEST_A: begin
                            buffer_next = RESP_PORT_TEST;
                            full_next   = 1'b1;
                            from_b_next = 1'b0;
                        end
                        CMD_DISABLE_A: config_next[CFG_DIS_A_BIT] = 1'b1;
                        CMD_ENABLE_A:  config_next[CFG_DIS_A_BIT] = 1'b0;
                        default:       res.status = ST_UNKNOWN;
                    endcase
                end else begin
                    if (pending_reg == PEND_CFG) begin
                        config_next = item.host_data;
                    end else begin
                        res.send_valid = 1'b1;
                        res.send_byte  = item.host_data;
                        res.send_port  = (pending_reg == PEND_PORT_B) && second_port_present;
                    end
                    pending_next = PEND_NONE;
                end
            end
            REQ_DEVICE: begin
                // disabled check wins over buffer full
                if (port_disabled) begin
                    res.status = ST_DROP_DISABLED;
                end else if (full_reg) begin
                    res.status = ST_DROP_FULL;
                end else begin
                    buffer_next = item.device_data;
                    full_next   = 1'b1;
                    from_b_next = item.device_port;
                end
            end
            default: res.status = ST_UNKNOWN;
        endcase

        res.irq_a = full_next & ~from_b_next & config_next[CFG_IRQ_A_BIT];
        res.irq_b = full_next &  from_b_next & config_next[CFG_IRQ_B_BIT];
    end

endmodule

// File: sv/ps2_controller_registers_core.sv
// Host-side register block of a two-channel ps/2 controller.
// Input channel s_*: one transfer is a host read, a host write (command or
// data) or a byte arriving from a device. Result channel m_*: exactly one
// result per input transfer, in order: read byte, byte forwarded to a
// device, interrupt levels and a status code.
// Configuration channel cfg_*: one bit, second port present; always ready.
// Write it only while no transfer is in flight.
// An accepted item is registered in the input register, decoded against the
// controller state and its result is registered in the result register.
// Throughput: one item per cycle while the receiver does not stall, set by
// the single decode stage between the input register and the result register.
// A stalled receiver holds the result register; the input register fills
// next and s_ready falls once both are occupied.
// Reset (aresetn low, synchronous) empties both registers, sets config to
// 0x30, clears the output buffer and any armed data write, and marks the
// second port present.
`timescale 1ns / 1ps

module ps2_controller_registers_core
    import ps2cr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic       s_is_command_port,
    input  logic [7:0] s_host_data,
    input  logic       s_device_port,
    input  logic [7:0] s_device_data,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_send_valid,
    output logic       m_send_port,
    output logic [7:0] m_send_byte,
    output logic       m_irq_a,
    output logic       m_irq_b,
    output logic [1:0] m_status
);

    logic    second_port_reg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t exec_res;
    logic    exec_fire;
    logic    out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            second_port_reg <= 1'b1;
        end else if (cfg_valid) begin
            second_port_reg <= cfg_data;
        end
    end

    assign out_free  = !out_valid_reg || m_ready;
    assign exec_fire = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= '{req_type:        s_req_type,
                             is_command_port: s_is_command_port,
                             host_data:       s_host_data,
                             device_port:     s_device_port,
                             device_data:     s_device_data};
        end
    end

    ps2cr_exec u_exec (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .fire                (exec_fire),
        .item                (in_item_reg),
        .second_port_present (second_port_reg),
        .res                 (exec_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= exec_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            out_res_reg <= exec_res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_read_data  = out_res_reg.read_data;
    assign m_send_valid = out_res_reg.send_valid;
    assign m_send_port  = out_res_reg.send_port;
    assign m_send_byte  = out_res_reg.send_byte;
    assign m_irq_a      = out_res_reg.irq_a;
    assign m_irq_b      = out_res_reg.irq_b;
    assign m_status     = out_res_reg.status;

endmodule

// File: sv/ps2cr_checker.sv
// port-level checks of the ps/2 controller register block, bound to the top
// depends on ps2cr_pkg and ps2_controller_registers_core_assert.svh
`timescale 1ns / 1ps
`include "ps2_controller_registers_core_assert.svh"

module ps2cr_checker
    import ps2cr_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_data,
    input logic       m_send_valid,
    input logic       m_send_port,
    input logic [7:0] m_send_byte,
    input logic       m_irq_a,
    input logic       m_irq_b,
    input logic [1:0] m_status
);

    // no result survives a reset
    `PS2CR_ASSERT_NXT_ALWAYS(a_reset_empties, aclk, !aresetn, !m_valid)

    // a stalled result transfer holds
    `PS2CR_ASSERT_NXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_read_data) && $stable(m_send_byte) && $stable(m_status))

    // nothing forwarded means no port and no byte
    `PS2CR_ASSERT_IMP(a_send_quiet, aclk, aresetn, m_valid && !m_send_valid,
        !m_send_port && m_send_byte == 8'h00)

    // a forwarded byte comes from a plain data write
    `PS2CR_ASSERT_IMP(a_send_clean, aclk, aresetn, m_valid && m_send_valid,
        m_status == ST_OK && m_read_data == 8'h00)

    // the buffered byte belongs to one port only
    `PS2CR_ASSERT_IMP(a_irq_exclusive, aclk, aresetn, m_valid,
        !(m_irq_a && m_irq_b))

endmodule

bind ps2_controller_registers_core ps2cr_checker u_ps2cr_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_data  (m_read_data),
    .m_send_valid (m_send_valid),
    .m_send_port  (m_send_port),
    .m_send_byte  (m_send_byte),
    .m_irq_a      (m_irq_a),
    .m_irq_b      (m_irq_b),
    .m_status     (m_status)
);
